[rtl/pee_pkg.sv]
// Shared package of the postfix expression evaluator.
// Holds sizes, symbol codes, command and status types and the state enums.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pee_pkg;

    // Sizes of the operand stack and of the datapath.
    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int STEP_W      = $clog2(DATA_W);

    // Character codes of the expression alphabet.
    localparam logic [SYM_W-1:0] SYM_END    = 8'h00;
    localparam logic [SYM_W-1:0] SYM_MUL    = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_ADD    = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_SUB    = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_DIV    = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_POW    = 8'h5E;
    localparam logic [SYM_W-1:0] SYM_DIG_LO = 8'h30;
    localparam logic [SYM_W-1:0] SYM_DIG_HI = 8'h39;
    localparam logic [SYM_W-1:0] SYM_UC_LO  = 8'h41;
    localparam logic [SYM_W-1:0] SYM_UC_HI  = 8'h5A;
    localparam logic [SYM_W-1:0] SYM_LC_LO  = 8'h61;
    localparam logic [SYM_W-1:0] SYM_LC_HI  = 8'h7A;

    // Sticky status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    // Kind of a classified command.
    typedef enum logic [1:0] {
        K_PUSH,
        K_OP,
        K_END
    } t_kind;

    // Arithmetic operations.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } t_op;

    // One command as it travels from the front end to the stack engine.
    typedef struct packed {
        t_kind             kind;
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_cmd;

    // Control between the stack engine and the arithmetic unit.
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic divz;
    } t_alu_rsp;

    // Stack engine states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_POP_L,
        B_EXEC,
        B_WAIT,
        B_END
    } t_back_state;

    // Arithmetic unit states.
    typedef enum logic [2:0] {
        A_IDLE,
        A_POW,
        A_DIV,
        A_FIX,
        A_DONE
    } t_alu_state;

    // The first error of an expression is kept.
    function automatic t_status flag_err(input t_status cur, input t_status code);
        flag_err = (cur == ST_OK) ? code : cur;
    endfunction

endpackage

`default_nettype wire

[rtl/postfix_expression_evaluator_top.sv]
// Postfix expression evaluator: one expression character per input request,
// one result request for each end-of-expression character.
//
// Input channel (i_in_valid / o_in_ready): i_symbol is the character and
// i_operand_value the value pushed for a letter. Digits push 0..9; the
// operators + - * / ^ pop right, then left, and push the wrapping result.
// Other nonzero characters are accepted and dropped. A zero character
// pops the final value and returns it with the sticky status on the
// output channel (o_out_valid / i_out_ready), then clears the stack.
// A push is done in the idle state of the stack engine, so pushes stream at
// one per cycle while that engine is idle; add and subtract go straight to
// the done state, multiply is one round of the power loop, divide makes one
// quotient bit per cycle in the arithmetic unit and power one exponent bit
// per round. A result passes the queue, the stack read and output registers.
// A two-entry queue sits between the front end and the stack engine, so input
// requests are taken while an operation runs or a result waits, until full.
// When the receiver stalls, the result stays in its output register and the
// stack engine holds at the end character until it is taken.
// Reset (synchronous, active low) empties the stack and the queue and clears
// the status; the stack memory itself needs no clearing.
// Depends on pee_pkg, pee_front, pee_alu and pee_back.
`default_nettype none

module postfix_expression_evaluator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [pee_pkg::SYM_W-1:0]     i_symbol,
    input  wire logic signed [pee_pkg::DATA_W-1:0] i_operand_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [pee_pkg::DATA_W-1:0]  o_final_value,
    output logic [1:0]                         o_status
);
    import pee_pkg::*;

    logic              cmd_valid;
    logic              cmd_ready;
    t_cmd              cmd;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic [DATA_W-1:0] alu_result;

    // Character classification and command queue.
    pee_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_symbol        (i_symbol),
        .i_operand_value (i_operand_value),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_ready     (cmd_ready),
        .o_cmd           (cmd)
    );

    // Stack engine with the operand memory and the result register.
    pee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .o_alu_req     (alu_req),
        .o_alu_a       (alu_a),
        .o_alu_b       (alu_b),
        .i_alu_rsp     (alu_rsp),
        .i_alu_result  (alu_result),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_final_value (o_final_value),
        .o_status      (o_status)
    );

    // Multi-cycle arithmetic unit.
    pee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

endmodule

`default_nettype wire

[rtl/pee_front.sv]
// Front end: accepts expression characters, classifies them and queues commands.
// Holds a two-entry command queue towards the stack engine. Depends on pee_pkg.
`default_nettype none

module pee_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [pee_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic signed [pee_pkg::DATA_W-1:0] i_operand_value,
    output logic                              o_cmd_valid,
    input  wire logic                         i_cmd_ready,
    output pee_pkg::t_cmd                     o_cmd
);
    import pee_pkg::*;

    logic       keep;
    t_cmd       cmd_in;
    logic       wr_en;
    logic       rd_en;
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic [1:0] n_fill;

    // Classify the character; characters outside the alphabet are dropped.
    always_comb begin
        keep         = 1'b1;
        cmd_in.kind  = K_PUSH;
        cmd_in.op    = OP_ADD;
        cmd_in.value = i_operand_value;
        unique case (i_symbol) inside
            SYM_END: begin
                cmd_in.kind = K_END;
            end
            [SYM_DIG_LO:SYM_DIG_HI]: begin
                cmd_in.value = {{(DATA_W-4){1'b0}}, i_symbol[3:0]};
            end
            [SYM_UC_LO:SYM_UC_HI], [SYM_LC_LO:SYM_LC_HI]: begin
                cmd_in.value = i_operand_value;
            end
            SYM_ADD: begin
                cmd_in.kind = K_OP;
                cmd_in.op   = OP_ADD;
            end
            SYM_SUB: begin
                cmd_in.kind = K_OP;
                cmd_in.op   = OP_SUB;
            end
            SYM_MUL: begin
                cmd_in.kind = K_OP;
                cmd_in.op   = OP_MUL;
            end
            SYM_DIV: begin
                cmd_in.kind = K_OP;
                cmd_in.op   = OP_DIV;
            end
            SYM_POW: begin
                cmd_in.kind = K_OP;
                cmd_in.op   = OP_POW;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Queue handshakes on both sides.
    assign o_in_ready  = (r_fill != 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign wr_en       = i_in_valid && o_in_ready && keep;
    assign rd_en       = o_cmd_valid && i_cmd_ready;

    // Fill level of the queue.
    always_comb begin
        case ({wr_en, rd_en})
            2'b10:   n_fill = r_fill + 2'd1;
            2'b01:   n_fill = r_fill - 2'd1;
            default: n_fill = r_fill;
        endcase
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            r_fill <= n_fill;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[rtl/pee_alu.sv]
// Arithmetic unit: add, subtract, multiply, divide and power on 32-bit words.
// Divide is restoring, one quotient bit per cycle; power is square-and-multiply.
// Depends on pee_pkg.
`default_nettype none

module pee_alu (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire pee_pkg::t_alu_req         i_req,
    input  wire logic [pee_pkg::DATA_W-1:0] i_a,
    input  wire logic [pee_pkg::DATA_W-1:0] i_b,
    output pee_pkg::t_alu_rsp              o_rsp,
    output logic [pee_pkg::DATA_W-1:0]     o_result
);
    import pee_pkg::*;

    t_alu_state        r_state;
    t_alu_state        n_state;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] n_acc;
    logic [DATA_W-1:0] r_base;
    logic [DATA_W-1:0] n_base;
    logic [DATA_W-1:0] r_exp;
    logic [DATA_W-1:0] n_exp;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] n_rem;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_neg;
    logic              n_neg;
    logic              r_divz;
    logic              n_divz;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] prod_acc;
    logic [DATA_W-1:0] prod_base;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    // Magnitudes of the operands for the divider.
    assign mag_a = i_a[DATA_W-1] ? (-i_a) : i_a;
    assign mag_b = i_b[DATA_W-1] ? (-i_b) : i_b;

    // One multiplier for the running product, one for squaring the base.
    assign prod_acc  = r_acc * r_base;
    assign prod_base = r_base * r_base;

    // Trial subtraction of the restoring divider.
    assign trial = {r_rem, r_acc[DATA_W-1]};
    assign diff  = trial - {1'b0, r_base};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    unique case (i_req.op) inside
                        OP_ADD, OP_SUB: n_state = A_DONE;
                        OP_MUL:         n_state = A_POW;
                        OP_DIV:         n_state = (i_b == '0) ? A_DONE : A_DIV;
                        OP_POW:         n_state = i_b[DATA_W-1] ? A_DONE : A_POW;
                        default:        n_state = A_DONE;
                    endcase
                end
            end
            A_POW: begin
                if (r_exp == '0) begin
                    n_state = A_DONE;
                end
            end
            A_DIV: begin
                if (r_step == '1) begin
                    n_state = A_FIX;
                end
            end
            A_FIX:   n_state = A_DONE;
            A_DONE:  n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    // Datapath and response.
    always_comb begin
        n_acc    = r_acc;
        n_base   = r_base;
        n_exp    = r_exp;
        n_rem    = r_rem;
        n_step   = r_step;
        n_neg    = r_neg;
        n_divz   = r_divz;
        o_rsp.done = (r_state == A_DONE);
        o_rsp.divz = r_divz;
        o_result   = r_acc;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_divz = 1'b0;
                    unique case (i_req.op)
                        OP_ADD: n_acc = i_a + i_b;
                        OP_SUB: n_acc = i_a - i_b;
                        // A multiply is one round of the power loop.
                        OP_MUL: begin
                            n_acc  = i_a;
                            n_base = i_b;
                            n_exp  = DATA_W'(1);
                        end
                        OP_DIV: begin
                            if (i_b == '0) begin
                                n_acc  = '0;
                                n_divz = 1'b1;
                            end else begin
                                n_acc  = mag_a;
                                n_base = mag_b;
                                n_rem  = '0;
                                n_step = '0;
                                n_neg  = i_a[DATA_W-1] ^ i_b[DATA_W-1];
                            end
                        end
                        OP_POW: begin
                            if (i_b[DATA_W-1]) begin
                                // Negative exponent: only a base of one or minus one survives.
                                if (i_a == DATA_W'(1)) begin
                                    n_acc = DATA_W'(1);
                                end else if (i_a == '1) begin
                                    n_acc = i_b[0] ? '1 : DATA_W'(1);
                                end else begin
                                    n_acc = '0;
                                end
                            end else begin
                                n_acc  = DATA_W'(1);
                                n_base = i_a;
                                n_exp  = i_b;
                            end
                        end
                        default: n_acc = '0;
                    endcase
                end
            end
            A_POW: begin
                if (r_exp != '0) begin
                    if (r_exp[0]) begin
                        n_acc = prod_acc;
                    end
                    n_base = prod_base;
                    n_exp  = r_exp >> 1;
                end
            end
            A_DIV: begin
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                end else begin
                    n_rem = trial[DATA_W-1:0];
                end
                n_acc  = {r_acc[DATA_W-2:0], ~diff[DATA_W]};
                n_step = r_step + STEP_W'(1);
            end
            A_FIX: begin
                if (r_neg) begin
                    n_acc = -r_acc;
                end
            end
            A_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_neg  <= n_neg;
        r_divz <= n_divz;
    end

endmodule

`default_nettype wire

[rtl/pee_back.sv]
// Stack engine: carries out queued commands on the operand stack memory.
// Owns the stack RAM, the sticky status and the result register.
// Depends on pee_pkg and drives the arithmetic unit pee_alu.
`default_nettype none

module pee_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    output logic                             o_cmd_ready,
    input  wire pee_pkg::t_cmd               i_cmd,
    output pee_pkg::t_alu_req                o_alu_req,
    output logic [pee_pkg::DATA_W-1:0]       o_alu_a,
    output logic [pee_pkg::DATA_W-1:0]       o_alu_b,
    input  wire pee_pkg::t_alu_rsp           i_alu_rsp,
    input  wire logic [pee_pkg::DATA_W-1:0]  i_alu_result,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [pee_pkg::DATA_W-1:0] o_final_value,
    output logic [1:0]                       o_status
);
    import pee_pkg::*;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_status           r_err;
    t_status           n_err;
    t_status           err_tmp;
    logic              r_rd_ok;
    logic              n_rd_ok;
    logic [DATA_W-1:0] r_right;
    logic [DATA_W-1:0] n_right;
    t_op               r_op;
    t_op               n_op;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [DATA_W-1:0] r_final;
    logic [DATA_W-1:0] n_final;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_stack [STACK_DEPTH];
    logic [DATA_W-1:0] r_mem_q;
    logic              mem_we;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_waddr;
    logic [PTR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [CNT_W-1:0]  cnt_m1;
    logic              empty;
    logic              full;
    logic [DATA_W-1:0] pop_data;
    logic              out_free;

    // Stack level and the value of the last pop (zero after an underflow).
    assign cnt_m1   = r_count - CNT_W'(1);
    assign empty    = (r_count == '0);
    assign full     = (r_count == CNT_W'(STACK_DEPTH));
    assign pop_data = r_rd_ok ? r_mem_q : '0;
    assign out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_OP:    n_state = B_POP_L;
                        K_END:   n_state = B_END;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_POP_L: n_state = B_EXEC;
            B_EXEC:  n_state = B_WAIT;
            B_WAIT: begin
                if (i_alu_rsp.done) begin
                    n_state = B_IDLE;
                end
            end
            B_END: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Stack operations, status and result register.
    always_comb begin
        o_cmd_ready     = 1'b0;
        n_count         = r_count;
        n_err           = r_err;
        err_tmp         = r_err;
        n_rd_ok         = r_rd_ok;
        n_right         = r_right;
        n_op            = r_op;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = r_count[PTR_W-1:0];
        mem_raddr       = cnt_m1[PTR_W-1:0];
        mem_wdata       = i_cmd.value;
        o_alu_req.start = 1'b0;
        o_alu_req.op    = r_op;
        o_alu_a         = pop_data;
        o_alu_b         = r_right;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_final         = r_final;
        n_status        = r_status;
        unique case (r_state)
            B_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_PUSH: begin
                            if (full) begin
                                n_err = flag_err(r_err, ST_OVER);
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        K_OP, K_END: begin
                            // Pop the right operand, or the final value.
                            n_op = i_cmd.op;
                            if (empty) begin
                                n_err   = flag_err(r_err, ST_UNDER);
                                n_rd_ok = 1'b0;
                            end else begin
                                mem_re  = 1'b1;
                                n_count = cnt_m1;
                                n_rd_ok = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_POP_L: begin
                // Keep the right operand and pop the left one.
                n_right = pop_data;
                if (empty) begin
                    n_err   = flag_err(r_err, ST_UNDER);
                    n_rd_ok = 1'b0;
                end else begin
                    mem_re  = 1'b1;
                    n_count = cnt_m1;
                    n_rd_ok = 1'b1;
                end
            end
            B_EXEC: begin
                o_alu_req.start = 1'b1;
            end
            B_WAIT: begin
                // Push the result once the arithmetic unit is done.
                if (i_alu_rsp.done) begin
                    if (i_alu_rsp.divz) begin
                        err_tmp = flag_err(r_err, ST_DIVZ);
                    end
                    n_err = err_tmp;
                    if (full) begin
                        n_err = flag_err(err_tmp, ST_OVER);
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = i_alu_result;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
            end
            B_END: begin
                // Emit the result and clear the stack for the next expression.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_final     = pop_data;
                    n_status    = r_err;
                    n_count     = '0;
                    n_err       = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Operand and result registers.
    always_ff @(posedge i_clk) begin
        r_rd_ok  <= n_rd_ok;
        r_right  <= n_right;
        r_op     <= n_op;
        r_final  <= n_final;
        r_status <= n_status;
    end

    // Operand stack memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_stack[mem_raddr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_final_value = r_final;
    assign o_status      = r_status;

    // The stack level never passes its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack level above depth");

    // A write to the stack only lands below the top of the memory.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_count < CNT_W'(STACK_DEPTH)))
        else $error("stack write on a full stack");

    // The arithmetic unit only reports completion while it is awaited.
    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_alu_rsp.done |-> (r_state == B_WAIT))
        else $error("arithmetic result outside the wait state");

    // Emitting a result leaves an empty stack and a clean status.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_END && out_free) |=> (r_count == '0 && r_err == ST_OK && r_out_valid))
        else $error("end of expression did not clear the stack");

endmodule

`default_nettype wire

[tb/sv/expr_result_checker.sv]
`timescale 1ns / 1ps
// Checker for the postfix expression evaluator: watches both request channels,
// evaluates every accepted character itself and compares each result request.
// Depends on pee_pkg for sizes, character codes and status codes.

module expr_result_checker
    import pee_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [DATA_W-1:0] i_operand_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [DATA_W-1:0] i_final_value,
    input  logic [1:0]        i_status,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_requests,
    output int                o_results,
    output int                o_under_hits,
    output int                o_over_hits,
    output int                o_divz_hits
);

    // One awaited result request.
    typedef struct {
        logic [DATA_W-1:0] value;
        t_status           status;
    } t_awaited_result;

    t_awaited_result   awaited_results[$];

    // Own copy of the operand stack and the sticky status.
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int unsigned       stack_level;
    t_status           sticky;

    // Only the first error of an expression is kept.
    function automatic void note_error(input t_status code);
        if (sticky == ST_OK) begin
            sticky = code;
        end
    endfunction

    // A push onto a full stack is dropped.
    function automatic void push_operand(input logic [DATA_W-1:0] v);
        if (stack_level >= STACK_DEPTH) begin
            note_error(ST_OVER);
        end else begin
            stack_mem[stack_level] = v;
            stack_level++;
        end
    endfunction

    // A pop from an empty stack yields zero.
    function automatic logic [DATA_W-1:0] pop_operand();
        if (stack_level == 0) begin
            note_error(ST_UNDER);
            return '0;
        end
        stack_level--;
        return stack_mem[stack_level];
    endfunction

    // Signed division truncating toward zero, done on magnitudes so that the
    // most negative value divided by minus one wraps onto itself.
    function automatic logic [DATA_W-1:0] quotient(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] q;
        mag_a = a[DATA_W-1] ? -a : a;
        mag_b = b[DATA_W-1] ? -b : b;
        q     = mag_a / mag_b;
        return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
    endfunction

    // Wrapping power; a negative exponent only leaves something for a base
    // of plus or minus one.
    function automatic logic [DATA_W-1:0] raise(input logic [DATA_W-1:0] base,
                                                input logic [DATA_W-1:0] ex);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sq;
        logic [DATA_W-1:0] e;
        acc = 1;
        sq  = base;
        e   = ex;
        if (e[DATA_W-1]) begin
            if (base == 1) begin
                return 1;
            end
            if (base == '1) begin
                return e[0] ? '1 : 1;
            end
            return '0;
        end
        while (e != 0) begin
            if (e[0]) begin
                acc = acc * sq;
            end
            sq = sq * sq;
            e  = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [DATA_W-1:0] combine(input logic [DATA_W-1:0] lhs,
                                                  input logic [SYM_W-1:0]  op,
                                                  input logic [DATA_W-1:0] rhs);
        case (op)
            SYM_ADD: return lhs + rhs;
            SYM_SUB: return lhs - rhs;
            SYM_MUL: return lhs * rhs;
            SYM_DIV: begin
                if (rhs == 0) begin
                    note_error(ST_DIVZ);
                    return '0;
                end
                return quotient(lhs, rhs);
            end
            default: return raise(lhs, rhs);
        endcase
    endfunction

    // Evaluates one accepted character; an end character leaves a result.
    function automatic void evaluate_symbol(input logic [SYM_W-1:0]  sym,
                                            input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        t_awaited_result   res;
        if (sym == SYM_END) begin
            res.value  = pop_operand();
            res.status = sticky;
            awaited_results.push_back(res);
            stack_level = 0;
            sticky      = ST_OK;
        end else if (sym >= SYM_DIG_LO && sym <= SYM_DIG_HI) begin
            push_operand({{(DATA_W-SYM_W){1'b0}}, sym - SYM_DIG_LO});
        end else if ((sym >= SYM_UC_LO && sym <= SYM_UC_HI) ||
                     (sym >= SYM_LC_LO && sym <= SYM_LC_HI)) begin
            push_operand(val);
        end else if (sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL ||
                     sym == SYM_DIV || sym == SYM_POW) begin
            rhs = pop_operand();
            lhs = pop_operand();
            push_operand(combine(lhs, sym, rhs));
        end
    endfunction

    // Results are compared before the same edge's input request is evaluated;
    // a result can never belong to a character taken at that very edge.
    always @(posedge i_clk) begin : watch
        t_awaited_result head;
        if (!i_rst_n) begin
            awaited_results.delete();
            stack_level = 0;
            sticky      = ST_OK;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                case (t_status'(i_status))
                    ST_UNDER: o_under_hits++;
                    ST_OVER:  o_over_hits++;
                    ST_DIVZ:  o_divz_hits++;
                    default:  ;
                endcase
                if (awaited_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, value %0d status %0d",
                             $time, $signed(i_final_value), i_status);
                end else begin
                    head = awaited_results.pop_front();
                    if (i_final_value !== head.value) begin
                        o_fail_count++;
                        $display("%0t: final_value expected %0d, got %0d", $time,
                                 $signed(head.value), $signed(i_final_value));
                    end
                    if (i_status !== head.status) begin
                        o_fail_count++;
                        $display("%0t: status expected %0d, got %0d", $time,
                                 head.status, i_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                o_requests++;
                evaluate_symbol(i_symbol, i_operand_value);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the evaluator testbench: clock, reset, character stimulus and the
// result receiver, with a watchdog and the verdict.
// Depends on pee_pkg, postfix_expression_evaluator_top and expr_result_checker.

module tb;
    import pee_pkg::*;

    localparam int ITEM_TARGET  = 1050;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_AFTER   = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    // The longest quiet spell in a correct run is the long receiver hold plus
    // a power or divide and a gap or two; the limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 3000;

    // Characters the block ignores.
    localparam logic [SYM_W-1:0] SYM_AT  = 8'h40;
    localparam logic [SYM_W-1:0] SYM_TOP = 8'hFF;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [SYM_W-1:0]         i_symbol;
    logic signed [DATA_W-1:0] i_operand_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_final_value;
    logic [1:0]               o_status;

    int fail_count;
    int pending;
    int requests;
    int results;
    int under_hits;
    int over_hits;
    int divz_hits;

    bit send_burst;
    int requests_sent;

    postfix_expression_evaluator_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_symbol        (i_symbol),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_final_value   (o_final_value),
        .o_status        (o_status)
    );

    expr_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_symbol        (i_symbol),
        .i_operand_value (i_operand_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_final_value   (o_final_value),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_requests      (requests),
        .o_results       (results),
        .o_under_hits    (under_hits),
        .o_over_hits     (over_hits),
        .o_divz_hits     (divz_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Characters that do something: end, digits, letters and operators.
    function automatic bit counts_toward(input logic [SYM_W-1:0] sym);
        return sym == SYM_END ||
               (sym >= SYM_DIG_LO && sym <= SYM_DIG_HI) ||
               (sym >= SYM_UC_LO && sym <= SYM_UC_HI) ||
               (sym >= SYM_LC_LO && sym <= SYM_LC_HI) ||
               sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL ||
               sym == SYM_DIV || sym == SYM_POW;
    endfunction

    function automatic logic [SYM_W-1:0] digit(input int n);
        return SYM_DIG_LO + SYM_W'(n);
    endfunction

    function automatic logic [SYM_W-1:0] draw_operator();
        case ($urandom_range(0, 4))
            0:       return SYM_ADD;
            1:       return SYM_SUB;
            2:       return SYM_MUL;
            3:       return SYM_DIV;
            default: return SYM_POW;
        endcase
    endfunction

    // Operand values lean towards small numbers and the extremes, so that
    // powers, zero divisors and wrapping all turn up often.
    function automatic logic [DATA_W-1:0] draw_operand();
        case ($urandom_range(0, 5))
            0: return DATA_W'($urandom_range(0, 12));
            1: return -DATA_W'($urandom_range(1, 12));
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Offers one input request after a random gap (none in a burst) and waits for it to be taken.
    task automatic offer(input logic [SYM_W-1:0] sym, input logic [DATA_W-1:0] val);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_symbol        <= sym;
        i_operand_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (counts_toward(sym)) begin
            requests_sent++;
        end
    endtask

    task automatic push_random_operand();
        logic [SYM_W-1:0] first;
        if ($urandom_range(0, 1) == 0) begin
            offer(digit($urandom_range(0, 9)), $urandom());
        end else begin
            first = ($urandom_range(0, 1) == 0) ? SYM_UC_LO : SYM_LC_LO;
            offer(first + SYM_W'($urandom_range(0, 25)), draw_operand());
        end
    endtask

    // One expression with a given number of operands. Most are well formed;
    // some carry surplus operators, some stop before reducing, and a few
    // stray characters fall in between. A pile pushes everything first.
    task automatic send_expression(input int operands, input bit pile);
        int level;
        int pushed;
        int flavour;
        level      = 0;
        pushed     = 0;
        flavour    = $urandom_range(0, 9);
        send_burst = ($urandom_range(0, 3) == 0);
        while (pushed < operands || (level > 1 && flavour != 1)) begin
            if (pushed < operands &&
                (pile || level < 2 || $urandom_range(0, 2) != 0)) begin
                push_random_operand();
                pushed++;
                level++;
            end else begin
                offer(draw_operator(), $urandom());
                level--;
            end
            if ($urandom_range(0, 24) == 0) begin
                offer(SYM_W'($urandom_range(0, 255)), $urandom());
            end
        end
        if (flavour == 0) begin
            repeat ($urandom_range(1, 3)) offer(draw_operator(), $urandom());
        end
        offer(SYM_END, $urandom());
    endtask

    // Receiver: random stalls per result, calm stretches, and one long hold
    // that backs the block up until it stops taking input requests.
    initial begin : receiver
        int gap;
        int taken;
        bit held;
        bit calm;
        i_out_ready = 1'b0;
        taken       = 0;
        held        = 1'b0;
        calm        = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken % 8 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (!held && taken == HOLD_AFTER) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL postfix_expression_evaluator_top");
        $finish;
    end

    initial begin : stimulus
        int expressions;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_symbol        = SYM_END;
        i_operand_value = '0;
        send_burst      = 1'b0;
        requests_sent   = 0;
        expressions     = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Largest plus smallest operand wraps to minus one.
        offer(SYM_UC_LO, 32'h7FFF_FFFF);
        offer(SYM_LC_HI, 32'h8000_0000);
        offer(SYM_ADD, $urandom());
        offer(SYM_END, $urandom());
        // Most negative value over minus one wraps onto itself.
        offer(SYM_UC_HI, 32'h8000_0000);
        offer(SYM_LC_LO, 32'hFFFF_FFFF);
        offer(SYM_DIV, $urandom());
        offer(SYM_END, $urandom());
        // Divide by zero, then an underflow that must not replace it.
        offer(digit(7), $urandom());
        offer(digit(0), $urandom());
        offer(SYM_DIV, $urandom());
        offer(SYM_ADD, $urandom());
        offer(SYM_END, $urandom());
        // End of an empty expression.
        offer(SYM_END, $urandom());
        // Zero to the zero, minus one and one to negative exponents, and
        // ignored characters in between.
        offer(digit(0), $urandom());
        offer(digit(0), $urandom());
        offer(SYM_POW, $urandom());
        offer(SYM_LC_LO, 32'hFFFF_FFFF);
        offer(SYM_UC_LO, -32'sd7);
        offer(SYM_POW, $urandom());
        offer(SYM_MUL, $urandom());
        offer(SYM_AT, $urandom());
        offer(SYM_TOP, $urandom());
        offer(digit(1), $urandom());
        offer(SYM_UC_HI, -32'sd2);
        offer(SYM_POW, $urandom());
        offer(SYM_SUB, $urandom());
        offer(SYM_END, $urandom());

        // Random expressions; every so often a pile of 64 to 72 operands that fills the stack and mostly overflows it.
        while (requests_sent < ITEM_TARGET) begin
            if (expressions % 25 == 3) begin
                send_expression($urandom_range(64, 72), 1'b1);
            end else begin
                send_expression($urandom_range(1, 8), 1'b0);
            end
            expressions++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Evaluated %0d expressions from %0d input requests.", results, requests);
        $display("Results with underflow %0d, overflow %0d, divide by zero %0d.",
                 under_hits, over_hits, divz_hits);
        if (fail_count == 0) begin
            $display("PASS postfix_expression_evaluator_top");
        end else begin
            $display("FAIL postfix_expression_evaluator_top");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pee_pkg.sv
rtl/pee_front.sv
rtl/pee_alu.sv
rtl/pee_back.sv
rtl/postfix_expression_evaluator_top.sv
tb/sv/expr_result_checker.sv
tb/sv/tb.sv
